/* rtl/cob_pkg.sv */
`timescale 1ns / 1ps

package cob_pkg;

  // Pixel layouts. Code 3 carries the word through untouched.
  typedef enum logic [1:0] {
    FMT_ARGB8888 = 2'd0,
    FMT_RGB888   = 2'd1,
    FMT_RGB565   = 2'd2,
    FMT_RAW      = 2'd3
  } pix_fmt_t;

  localparam logic [2:0] REG_ALPHA  = 3'd0;
  localparam logic [2:0] REG_RED    = 3'd1;
  localparam logic [2:0] REG_GREEN  = 3'd2;
  localparam logic [2:0] REG_BLUE   = 3'd3;
  localparam logic [2:0] REG_FORMAT = 3'd4;

  // Channel lanes: index 2 is red, 1 is green, 0 is blue.
  localparam int unsigned NumChan = 3;
  localparam int unsigned DivSteps = 16;

  typedef logic [NumChan-1:0][7:0] chan_t;

  // Widen a 5-bit channel to 8 bits.
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [13:0] t;
    t = 14'(v) * 14'd527 + 14'd23;
    return t[13:6];
  endfunction

  // Widen a 6-bit channel to 8 bits.
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] t;
    t = 14'(v) * 14'd259 + 14'd33;
    return t[13:6];
  endfunction

  // Floor of x / 255, exact for every x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

/* rtl/color_overlay_blend.sv */
`timescale 1ns / 1ps
// A three-stage pipeline (unpack, multiply, scale) registers each pixel taken with start
// and shows it on pixel_out with done; one pixel per cycle while busy is low.
// A register write keeps busy high while a radix-2 divider with 16 steps
// unmultiplies the overlay color. Reset is synchronous: alpha 255, color 0, ARGB8888.
// The receiver cannot stall: each word on pixel_out is valid for the single cycle of done.
module color_overlay_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pixel_in,
  input  logic        last_pixel,
  output logic        done,
  output logic [31:0] pixel_out,
  output logic        last_out,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [7:0]  wr_data
);
  import cob_pkg::*;

  // Configuration registers and their next values.
  logic [7:0] overlay_alpha, alpha_next;
  chan_t      overlay_color, color_next;
  pix_fmt_t   pixel_format, format_next;
  logic       cfg_hit;

  // Unmultiplied overlay and the divider that produces it.
  chan_t                          unmul;
  logic [7:0]                     div_alpha;
  logic [4:0]                     div_cnt;
  logic                           div_busy;
  logic [NumChan-1:0][7:0]        div_rem, div_rem_next;
  logic [NumChan-1:0][15:0]       div_quo, div_quo_next;
  logic [NumChan-1:0][15:0]       dividend;

  always_comb begin
    alpha_next  = overlay_alpha;
    color_next  = overlay_color;
    format_next = pixel_format;
    cfg_hit     = 1'b0;
    if (wr_en) begin
      case (wr_index)
        REG_ALPHA: begin
          alpha_next = wr_data;
          cfg_hit    = 1'b1;
        end
        REG_RED: begin
          color_next[2] = wr_data;
          cfg_hit       = 1'b1;
        end
        REG_GREEN: begin
          color_next[1] = wr_data;
          cfg_hit       = 1'b1;
        end
        REG_BLUE: begin
          color_next[0] = wr_data;
          cfg_hit       = 1'b1;
        end
        REG_FORMAT: begin
          format_next = pix_fmt_t'(wr_data[1:0]);
          cfg_hit     = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [8:0] rem_shift;
    for (int i = 0; i < NumChan; i++) begin
      dividend[i]  = {color_next[i], 8'h00} - 16'(color_next[i]);
      rem_shift    = {div_rem[i], div_quo[i][15]};
      if (rem_shift >= {1'b0, div_alpha}) begin
        div_rem_next[i] = 8'(rem_shift - {1'b0, div_alpha});
        div_quo_next[i] = {div_quo[i][14:0], 1'b1};
      end else begin
        div_rem_next[i] = rem_shift[7:0];
        div_quo_next[i] = {div_quo[i][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_alpha <= 8'd255;
      overlay_color <= '0;
      pixel_format  <= FMT_ARGB8888;
      unmul         <= '0;
      div_busy      <= 1'b0;
      div_cnt       <= '0;
    end else begin
      overlay_alpha <= alpha_next;
      overlay_color <= color_next;
      pixel_format  <= format_next;
      if (cfg_hit) begin
        // Any write to a defined register restarts the divider on the freshly written values.
        div_busy <= 1'b1;
        div_cnt  <= 5'(DivSteps);
      end else if (div_busy) begin
        if (div_cnt != '0) begin
          div_cnt <= div_cnt - 5'd1;
        end else begin
          div_busy <= 1'b0;
          for (int i = 0; i < NumChan; i++) begin
            unmul[i] <= (div_alpha == '0) ? 8'h00 : div_quo[i][7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_hit) begin
      div_alpha <= alpha_next;
      div_rem   <= '0;
      div_quo   <= dividend;
    end else if (div_busy && div_cnt != '0) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
    end
  end

  assign busy = div_busy;

  // Stage 1: unpack the word into three 8-bit channels.
  logic        s1_valid, s2_valid;
  pix_fmt_t    s1_fmt, s2_fmt;
  logic [31:0] s1_raw, s2_raw;
  logic        s1_last, s2_last;
  chan_t       s1_chan, unpack_chan;
  logic [NumChan-1:0][15:0] s2_sum, blend_sum;
  logic        accept;

  assign accept = start && !div_busy;

  always_comb begin
    case (pixel_format)
      FMT_ARGB8888, FMT_RGB888: begin
        unpack_chan = {pixel_in[23:16], pixel_in[15:8], pixel_in[7:0]};
      end
      FMT_RGB565: begin
        unpack_chan = {expand5(pixel_in[15:11]), expand6(pixel_in[10:5]),
                       expand5(pixel_in[4:0])};
      end
      default: unpack_chan = '0;
    endcase
  end

  // Stage 2: weight overlay and background by alpha and its complement.
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      blend_sum[i] = 16'(unmul[i]) * 16'(overlay_alpha)
                   + 16'(s1_chan[i]) * 16'(8'd255 - overlay_alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_fmt  <= pixel_format;
    s1_raw  <= pixel_in;
    s1_last <= last_pixel;
    s1_chan <= unpack_chan;
    s2_fmt  <= s1_fmt;
    s2_raw  <= s1_raw;
    s2_last <= s1_last;
    s2_sum  <= blend_sum;
  end

  // Stage 3: scale by 1/255 and repack in the pixel's own layout.
  chan_t       mix;
  logic [31:0] packed_word;

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      mix[i] = div255(s2_sum[i]);
    end
    case (s2_fmt)
      FMT_ARGB8888: packed_word = {8'hFF, mix[2], mix[1], mix[0]};
      FMT_RGB888:   packed_word = {8'h00, mix[2], mix[1], mix[0]};
      FMT_RGB565:   packed_word = {16'h0000, mix[2][7:3], mix[1][7:2], mix[0][7:3]};
      FMT_RAW:      packed_word = s2_raw;
      default:      packed_word = s2_raw;
    endcase
  end

  always_ff @(posedge clk) begin
    pixel_out <= packed_word;
    last_out  <= s2_last;
  end

endmodule
